@@ rtl/idmc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idmc_pkg
// Types and constants of the IoU / direction matching cost pipeline.
// ----------------------------------------------------------------------------
package idmc_pkg;

    localparam int Q15_ONE          = 32768;
    localparam int VEL_WEIGHT_RST   = 6554;
    localparam int APP_WEIGHT_RST   = 0;

    localparam int IOU_STEPS        = 15;
    localparam int DIV_STEPS        = 34;
    localparam int SQRT_STEPS       = 17;
    localparam int FRONT_STAGES     = 4;
    localparam int BACK_STAGES      = 5;
    localparam int PIPE_DEPTH       = FRONT_STAGES + (DIV_STEPS + 1) + (SQRT_STEPS + 1)
                                      + BACK_STAGES;

    localparam logic REG_VELOCITY   = 1'b0;
    localparam logic REG_APPEARANCE = 1'b1;

    typedef struct packed {
        logic [29:0] rem;
        logic [28:0] den;
        logic [33:0] num;
        logic [33:0] quo;
        logic        dneg;
        logic [35:0] irem;
        logic [35:0] iden;
        logic [14:0] iquo;
        logic        izero;
        logic        isat;
        logic        app_v;
        logic [15:0] app_s;
    } t_div_stage;

    typedef struct packed {
        logic [33:0] rad;
        logic [19:0] rem;
        logic [16:0] root;
        logic        dneg;
        logic [15:0] iou;
        logic        app_v;
        logic [15:0] app_s;
    } t_sqrt_stage;

    function automatic logic [15:0] clamp_q15(input logic signed [35:0] x);
        logic [15:0] r;
        if (x < 0) begin
            r = '0;
        end else if (x > 36'(Q15_ONE)) begin
            r = 16'(Q15_ONE);
        end else begin
            r = x[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/iou_direction_match_cost.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iou_direction_match_cost
// Matching score of one detection / track pair: IoU blended with direction
// agreement, then optionally with an appearance score. All Q1.15.
// ----------------------------------------------------------------------------
// Channel   Handshake            Payload
// input     i_valid / o_stall    i_det_box .. i_appearance_score
// output    o_valid / i_stall    o_match_cost, o_overlap_ratio, o_motion_blend
// config    APB psel/penable     paddr, pwdata, prdata (2 registers)
//
// One transaction per cycle while the output is not stalled.
// Most of the pipeline lies in the bit-serial divider (34 stages) and the
// square root (17 stages), one quotient or root bit per stage.
// Synchronous active-low reset clears valid bits and resets the weight registers.
// A stall on the output while a result is held there freezes the whole pipeline;
// nothing is dropped.
module iou_direction_match_cost #(
    parameter int COORD_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [63:0] i_det_box,
    input  wire logic [63:0] i_track_box,
    input  wire logic [63:0] i_last_obs_box,
    input  wire logic signed [15:0] i_track_dir_x,
    input  wire logic signed [15:0] i_track_dir_y,
    input  wire logic        i_appearance_valid,
    input  wire logic [15:0] i_appearance_score,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_match_cost,
    output logic [15:0]      o_overlap_ratio,
    output logic [15:0]      o_motion_blend,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import idmc_pkg::*;

    function automatic logic signed [15:0] lane_f(input logic [15:0] v);
        logic signed [15:0] t;
        t = v << (16 - COORD_BITS);
        return t >>> (16 - COORD_BITS);
    endfunction

    function automatic t_div_stage div_step(input t_div_stage s, input int k);
        t_div_stage o;
        logic [30:0] t;
        logic [35:0] it;
        logic        ge;
        logic        ige;
        o  = s;
        t  = {s.rem, s.num[DIV_STEPS-1-k]};
        ge = (t >= {2'b00, s.den});
        o.rem = ge ? 30'(t - {2'b00, s.den}) : t[29:0];
        o.quo = {s.quo[DIV_STEPS-2:0], ge};
        if (k < IOU_STEPS) begin
            it     = {s.irem[34:0], 1'b0};
            ige    = (it >= s.iden);
            o.irem = ige ? (it - s.iden) : it;
            o.iquo = {s.iquo[IOU_STEPS-2:0], ige};
        end
        return o;
    endfunction

    function automatic t_sqrt_stage sqrt_step(input t_sqrt_stage s, input int j);
        t_sqrt_stage o;
        logic [19:0] t;
        logic [19:0] trial;
        logic        ge;
        o     = s;
        t     = {s.rem[17:0], s.rad[2*SQRT_STEPS-1-2*j -: 2]};
        trial = {1'b0, s.root, 2'b01};
        ge    = (t >= trial);
        o.rem  = ge ? (t - trial) : t;
        o.root = {s.root[15:0], ge};
        return o;
    endfunction

    // configuration
    logic [15:0] r_vel_weight;
    logic [15:0] r_app_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel_weight <= 16'(VEL_WEIGHT_RST);
            r_app_weight <= 16'(APP_WEIGHT_RST);
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_VELOCITY:   r_vel_weight <= pwdata[15:0];
                REG_APPEARANCE: r_app_weight <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_APPEARANCE) ? {16'b0, r_app_weight}
                                                  : {16'b0, r_vel_weight};

    // pipeline control
    logic [PIPE_DEPTH-1:0] r_vld;
    logic                  en;

    assign en      = !r_vld[PIPE_DEPTH-1] || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_valid};
        end
    end

    // stage A: edges, areas, center differences
    logic signed [15:0] d_x, d_y, d_w, d_h, t_x, t_y, t_w, t_h, l_x, l_y, l_w, l_h;
    logic signed [16:0] d_r, d_b, t_r, t_b, x2, y2;
    logic signed [15:0] x1, y1;
    logic signed [17:0] diff_x, diff_y, cd_x, cd_y, co_x, co_y;
    logic signed [18:0] dd_x, dd_y;

    logic [16:0]        r_a_iw, r_a_ih;
    logic signed [31:0] r_a_area_d, r_a_area_t;
    logic [17:0]        r_a_mx, r_a_my;
    logic               r_a_nx, r_a_ny;
    logic signed [15:0] r_a_tx, r_a_ty;
    logic               r_a_appv;
    logic [15:0]        r_a_apps;

    always_comb begin
        d_x = lane_f(i_det_box[15:0]);        d_y = lane_f(i_det_box[31:16]);
        d_w = lane_f(i_det_box[47:32]);       d_h = lane_f(i_det_box[63:48]);
        t_x = lane_f(i_track_box[15:0]);      t_y = lane_f(i_track_box[31:16]);
        t_w = lane_f(i_track_box[47:32]);     t_h = lane_f(i_track_box[63:48]);
        l_x = lane_f(i_last_obs_box[15:0]);   l_y = lane_f(i_last_obs_box[31:16]);
        l_w = lane_f(i_last_obs_box[47:32]);  l_h = lane_f(i_last_obs_box[63:48]);
        d_r = 17'(d_x) + 17'(d_w);
        d_b = 17'(d_y) + 17'(d_h);
        t_r = 17'(t_x) + 17'(t_w);
        t_b = 17'(t_y) + 17'(t_h);
        x1  = (d_x > t_x) ? d_x : t_x;
        y1  = (d_y > t_y) ? d_y : t_y;
        x2  = (d_r < t_r) ? d_r : t_r;
        y2  = (d_b < t_b) ? d_b : t_b;
        diff_x = 18'(x2) - 18'(x1);
        diff_y = 18'(y2) - 18'(y1);
        cd_x = (18'(d_x) <<< 1) + 18'(d_w);
        cd_y = (18'(d_y) <<< 1) + 18'(d_h);
        co_x = (18'(l_x) <<< 1) + 18'(l_w);
        co_y = (18'(l_y) <<< 1) + 18'(l_h);
        dd_x = 19'(cd_x) - 19'(co_x);
        dd_y = 19'(cd_y) - 19'(co_y);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_iw     <= (diff_x > 0) ? diff_x[16:0] : '0;
            r_a_ih     <= (diff_y > 0) ? diff_y[16:0] : '0;
            r_a_area_d <= d_w * d_h;
            r_a_area_t <= t_w * t_h;
            r_a_mx     <= (dd_x < 0) ? 18'(-dd_x) : dd_x[17:0];
            r_a_my     <= (dd_y < 0) ? 18'(-dd_y) : dd_y[17:0];
            r_a_nx     <= dd_x < 0;
            r_a_ny     <= dd_y < 0;
            r_a_tx     <= i_track_dir_x;
            r_a_ty     <= i_track_dir_y;
            r_a_appv   <= i_appearance_valid;
            r_a_apps   <= i_appearance_score;
        end
    end

    // stage B: intersection, direction scaling
    logic [17:0]        b_or;
    logic [2:0]         b_sh;
    logic [13:0]        b_mx, b_my;

    logic [33:0]        r_b_inter;
    logic signed [31:0] r_b_area_d, r_b_area_t;
    logic signed [14:0] r_b_sx, r_b_sy;
    logic [13:0]        r_b_mx, r_b_my;
    logic               r_b_zero;
    logic signed [15:0] r_b_tx, r_b_ty;
    logic               r_b_appv;
    logic [15:0]        r_b_apps;

    always_comb begin
        b_or = r_a_mx | r_a_my;
        if (b_or[17])      b_sh = 3'd4;
        else if (b_or[16]) b_sh = 3'd3;
        else if (b_or[15]) b_sh = 3'd2;
        else if (b_or[14]) b_sh = 3'd1;
        else               b_sh = 3'd0;
        b_mx = 14'(r_a_mx >> b_sh);
        b_my = 14'(r_a_my >> b_sh);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_inter  <= r_a_iw * r_a_ih;
            r_b_area_d <= r_a_area_d;
            r_b_area_t <= r_a_area_t;
            r_b_sx     <= r_a_nx ? -$signed({1'b0, b_mx}) : $signed({1'b0, b_mx});
            r_b_sy     <= r_a_ny ? -$signed({1'b0, b_my}) : $signed({1'b0, b_my});
            r_b_mx     <= b_mx;
            r_b_my     <= b_my;
            r_b_zero   <= b_or == '0;
            r_b_tx     <= r_a_tx;
            r_b_ty     <= r_a_ty;
            r_b_appv   <= r_a_appv;
            r_b_apps   <= r_a_apps;
        end
    end

    // stage C: union, dot product terms, squared length
    logic [27:0]        c_mx2, c_my2;

    logic signed [35:0] r_c_uni;
    logic [33:0]        r_c_inter;
    logic signed [30:0] r_c_px, r_c_py;
    logic [28:0]        r_c_sum;
    logic               r_c_zero;
    logic               r_c_appv;
    logic [15:0]        r_c_apps;

    always_comb begin
        c_mx2 = r_b_mx * r_b_mx;
        c_my2 = r_b_my * r_b_my;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_uni   <= 36'(r_b_area_d) + 36'(r_b_area_t) - $signed({2'b00, r_b_inter});
            r_c_inter <= r_b_inter;
            r_c_px    <= r_b_sx * r_b_tx;
            r_c_py    <= r_b_sy * r_b_ty;
            r_c_sum   <= {1'b0, c_mx2} + {1'b0, c_my2};
            r_c_zero  <= r_b_zero;
            r_c_appv  <= r_b_appv;
            r_c_apps  <= r_b_apps;
        end
    end

    // stage D: IoU special cases, dot magnitude
    logic signed [31:0] d_dot;
    logic               d_izero;

    logic [30:0]        r_d_mag;
    logic               r_d_dneg;
    logic [28:0]        r_d_sum;
    logic               r_d_zero;
    logic [33:0]        r_d_inter;
    logic [35:0]        r_d_uni;
    logic               r_d_izero, r_d_isat;
    logic               r_d_appv;
    logic [15:0]        r_d_apps;

    always_comb begin
        d_dot   = 32'(r_c_px) + 32'(r_c_py);
        d_izero = r_c_uni <= 0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_mag   <= (d_dot < 0) ? 31'(-d_dot) : d_dot[30:0];
            r_d_dneg  <= d_dot < 0;
            r_d_sum   <= r_c_sum;
            r_d_zero  <= r_c_zero;
            r_d_inter <= r_c_inter;
            r_d_uni   <= r_c_uni;
            r_d_izero <= d_izero;
            r_d_isat  <= !d_izero && ($signed({2'b00, r_c_inter}) >= r_c_uni);
            r_d_appv  <= r_c_appv;
            r_d_apps  <= r_c_apps;
        end
    end

    // divider: 4*dot^2 / |d|^2 and inter*2^15 / union, one bit per stage
    logic [61:0] e_m2;
    logic [63:0] e_num;
    t_div_stage  e_init;
    t_div_stage  r_div [0:DIV_STEPS];
    t_div_stage  n_div [1:DIV_STEPS];

    always_comb begin
        e_m2  = r_d_mag * r_d_mag;
        e_num = {e_m2, 2'b00};
        e_init       = '0;
        e_init.dneg  = r_d_dneg;
        e_init.izero = r_d_izero;
        e_init.isat  = r_d_isat;
        e_init.app_v = r_d_appv;
        e_init.app_s = r_d_apps;
        if (r_d_zero) begin
            e_init.den = 29'd1;
        end else begin
            e_init.rem = e_num[63:DIV_STEPS];
            e_init.num = e_num[DIV_STEPS-1:0];
            e_init.den = r_d_sum;
        end
        if (r_d_izero || r_d_isat) begin
            e_init.iden = 36'd1;
        end else begin
            e_init.irem = {2'b00, r_d_inter};
            e_init.iden = r_d_uni;
        end
        for (int k = 0; k < DIV_STEPS; k++) begin
            n_div[k+1] = div_step(r_div[k], k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_div[0] <= e_init;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_div[k] <= n_div[k];
            end
        end
    end

    // square root, one root bit per stage
    t_sqrt_stage s_init;
    t_sqrt_stage r_sq [0:SQRT_STEPS];
    t_sqrt_stage n_sq [1:SQRT_STEPS];

    always_comb begin
        s_init       = '0;
        s_init.rad   = r_div[DIV_STEPS].quo;
        s_init.dneg  = r_div[DIV_STEPS].dneg;
        s_init.app_v = r_div[DIV_STEPS].app_v;
        s_init.app_s = r_div[DIV_STEPS].app_s;
        if (r_div[DIV_STEPS].izero) begin
            s_init.iou = '0;
        end else if (r_div[DIV_STEPS].isat) begin
            s_init.iou = 16'(Q15_ONE);
        end else begin
            s_init.iou = {1'b0, r_div[DIV_STEPS].iquo};
        end
        for (int j = 0; j < SQRT_STEPS; j++) begin
            n_sq[j+1] = sqrt_step(r_sq[j], j);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq[0] <= s_init;
            for (int j = 1; j <= SQRT_STEPS; j++) begin
                r_sq[j] <= n_sq[j];
            end
        end
    end

    // stage F: normalized direction
    logic signed [17:0] f_cos;
    logic signed [18:0] f_ofs;

    logic signed [17:0] r_f_nd;
    logic [15:0]        r_f_iou;
    logic               r_f_appv;
    logic [15:0]        r_f_apps;

    always_comb begin
        f_cos = r_sq[SQRT_STEPS].dneg ? -$signed({1'b0, r_sq[SQRT_STEPS].root})
                                      : $signed({1'b0, r_sq[SQRT_STEPS].root});
        f_ofs = 19'(f_cos) + 19'(Q15_ONE);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_nd   <= f_ofs[18:1];
            r_f_iou  <= r_sq[SQRT_STEPS].iou;
            r_f_appv <= r_sq[SQRT_STEPS].app_v;
            r_f_apps <= r_sq[SQRT_STEPS].app_s;
        end
    end

    // stage G: motion blend products
    logic signed [16:0] g_wc;

    logic signed [33:0] r_g_p1;
    logic signed [34:0] r_g_p2;
    logic [15:0]        r_g_iou;
    logic               r_g_appv;
    logic [15:0]        r_g_apps;

    assign g_wc = 17'(Q15_ONE) - $signed({1'b0, r_vel_weight});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_p1   <= g_wc * $signed({1'b0, r_f_iou});
            r_g_p2   <= $signed({1'b0, r_vel_weight}) * r_f_nd;
            r_g_iou  <= r_f_iou;
            r_g_appv <= r_f_appv;
            r_g_apps <= r_f_apps;
        end
    end

    // stage H: motion score
    logic signed [35:0] h_sum;

    logic [15:0]        r_h_motion;
    logic [15:0]        r_h_iou;
    logic               r_h_appv;
    logic [15:0]        r_h_apps;

    assign h_sum = 36'(r_g_p1) + 36'(r_g_p2);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_motion <= clamp_q15(h_sum >>> 15);
            r_h_iou    <= r_g_iou;
            r_h_appv   <= r_g_appv;
            r_h_apps   <= r_g_apps;
        end
    end

    // stage I: appearance blend products
    logic signed [16:0] i_wc;

    logic signed [33:0] r_i_p3, r_i_p4;
    logic [15:0]        r_i_motion;
    logic [15:0]        r_i_iou;
    logic               r_i_appv;

    assign i_wc = 17'(Q15_ONE) - $signed({1'b0, r_app_weight});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i_p3     <= i_wc * $signed({1'b0, r_h_motion});
            r_i_p4     <= $signed({1'b0, r_app_weight}) * $signed({1'b0, r_h_apps});
            r_i_motion <= r_h_motion;
            r_i_iou    <= r_h_iou;
            r_i_appv   <= r_h_appv;
        end
    end

    // output register
    logic signed [35:0] o_sum;
    logic [15:0]        r_out_cost, r_out_iou, r_out_motion;

    assign o_sum = 36'(r_i_p3) + 36'(r_i_p4);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_cost   <= r_i_appv ? clamp_q15(o_sum >>> 15) : r_i_motion;
            r_out_iou    <= r_i_iou;
            r_out_motion <= r_i_motion;
        end
    end

    assign o_match_cost    = r_out_cost;
    assign o_overlap_ratio = r_out_iou;
    assign o_motion_blend  = r_out_motion;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted transaction not in first stage");

    a_last_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld[PIPE_DEPTH-2]) |=> o_valid)
        else $error("transaction lost before output register");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_match_cost <= 16'(Q15_ONE) && o_overlap_ratio <= 16'(Q15_ONE)
                     && o_motion_blend <= 16'(Q15_ONE)))
        else $error("result outside Q1.15 range");

    a_zero_app_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_app_weight == '0) |-> (o_match_cost == o_motion_blend))
        else $error("zero appearance weight changed the cost");

endmodule
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Bench for iou_direction_match_cost: directed and random detection/track pairs
// through the pipeline, each result compared with a local integer model of IoU,
// direction agreement and the two weighted blends, or with a directed row's expected values.
// ----------------------------------------------------------------------------
module tb;
    import idmc_pkg::*;

    typedef struct {
        logic [63:0] det;
        logic [63:0] trk;
        logic [63:0] obs;
        logic [15:0] dx;
        logic [15:0] dy;
        logic        av;
        logic [15:0] as;
        bit          has_exp;
        logic [15:0] e_cost;
        logic [15:0] e_iou;
        logic [15:0] e_motion;
    } t_pair;

    typedef struct {
        logic [15:0] cost;
        logic [15:0] iou;
        logic [15:0] motion;
    } t_score;

    localparam int LATENCY = PIPE_DEPTH;
    localparam int LIMIT   = 2000000;
    localparam int N_RAND  = 800;

    localparam logic [2:0] ADDR_VELOCITY   = {REG_VELOCITY, 2'b00};
    localparam logic [2:0] ADDR_APPEARANCE = {REG_APPEARANCE, 2'b00};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_det_box;
    logic [63:0] i_track_box;
    logic [63:0] i_last_obs_box;
    logic signed [15:0] i_track_dir_x;
    logic signed [15:0] i_track_dir_y;
    logic        i_appearance_valid;
    logic [15:0] i_appearance_score;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_match_cost;
    logic [15:0] o_overlap_ratio;
    logic [15:0] o_motion_blend;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    iou_direction_match_cost dut (.*);

    logic [15:0] vel_w;
    logic [15:0] app_w;
    t_score      score_q[$];
    int          errors;
    int          n_checked;
    int          cycles;
    bit          quiet;
    bit          sink_idle_en;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("%0t timeout", $time);
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic longint coord(logic [63:0] b, int idx);
        return longint'($signed(b[16*idx +: 16]));
    endfunction

    function automatic longint iou_q15(logic [63:0] a, logic [63:0] b);
        longint x1, y1, x2, y2, iw, ih, inter, uni, r;
        x1 = coord(a, 0) > coord(b, 0) ? coord(a, 0) : coord(b, 0);
        y1 = coord(a, 1) > coord(b, 1) ? coord(a, 1) : coord(b, 1);
        x2 = (coord(a, 0) + coord(a, 2)) < (coord(b, 0) + coord(b, 2)) ?
             coord(a, 0) + coord(a, 2) : coord(b, 0) + coord(b, 2);
        y2 = (coord(a, 1) + coord(a, 3)) < (coord(b, 1) + coord(b, 3)) ?
             coord(a, 1) + coord(a, 3) : coord(b, 1) + coord(b, 3);
        iw = x2 - x1 > 0 ? x2 - x1 : 0;
        ih = y2 - y1 > 0 ? y2 - y1 : 0;
        inter = iw * ih;
        uni = coord(a, 2) * coord(a, 3) + coord(b, 2) * coord(b, 3) - inter;
        if (uni <= 0) return 0;
        r = (inter * Q15_ONE) / uni;
        return r > Q15_ONE ? Q15_ONE : r;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint heading_agreement(logic [63:0] det, logic [63:0] obs,
                                                 longint tx, longint ty);
        longint ddx, ddy, sx, sy, dotp, cosv;
        longint unsigned mx, my, sum, mag, q;
        ddx = (2 * coord(det, 0) + coord(det, 2)) - (2 * coord(obs, 0) + coord(obs, 2));
        ddy = (2 * coord(det, 1) + coord(det, 3)) - (2 * coord(obs, 1) + coord(obs, 3));
        mx = ddx < 0 ? -ddx : ddx;
        my = ddy < 0 ? -ddy : ddy;
        if (mx == 0 && my == 0) begin
            cosv = 0;
        end else begin
            while (mx >= 16384 || my >= 16384) begin
                mx >>= 1;
                my >>= 1;
            end
            sx = ddx < 0 ? -longint'(mx) : longint'(mx);
            sy = ddy < 0 ? -longint'(my) : longint'(my);
            dotp = sx * tx + sy * ty;
            sum = mx * mx + my * my;
            mag = dotp < 0 ? -dotp : dotp;
            q = (4 * mag * mag) / sum;
            cosv = int_sqrt(q);
            if (dotp < 0) cosv = -cosv;
        end
        return ((cosv + Q15_ONE + 262144) >>> 1) - 131072;
    endfunction

    function automatic longint blend(longint w, longint a, longint b);
        longint x;
        x = (Q15_ONE - w) * a + w * b;
        x = x >= 0 ? x >>> 15 : -((-x + 32767) >>> 15);
        return x < 0 ? 0 : (x > Q15_ONE ? Q15_ONE : x);
    endfunction

    function automatic t_score score_pair(t_pair p);
        t_score s;
        longint iou, nd, mot, cst;
        iou = iou_q15(p.det, p.trk);
        nd = heading_agreement(p.det, p.obs, longint'($signed(p.dx)),
                               longint'($signed(p.dy)));
        mot = blend(vel_w, iou, nd);
        cst = p.av ? blend(app_w, mot, p.as) : mot;
        s.cost = cst[15:0];
        s.iou = iou[15:0];
        s.motion = mot[15:0];
        return s;
    endfunction

    function automatic logic [63:0] mkbox(int x, int y, int w, int h);
        return {16'(h), 16'(w), 16'(y), 16'(x)};
    endfunction

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (addr == ADDR_VELOCITY) vel_w = data[15:0];
        else if (addr == ADDR_APPEARANCE) app_w = data[15:0];
    endtask

    task automatic drain();
        while (score_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_pair(t_pair p);
        t_score s;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        s = score_pair(p);
        if (p.has_exp && (s.cost != p.e_cost || s.iou != p.e_iou || s.motion != p.e_motion))
            $display("%0t note: directed row differs from model", $time);
        if (p.has_exp) begin
            s.cost = p.e_cost; s.iou = p.e_iou; s.motion = p.e_motion;
        end
        i_valid = 1'b1;
        i_det_box = p.det; i_track_box = p.trk; i_last_obs_box = p.obs;
        i_track_dir_x = p.dx; i_track_dir_y = p.dy;
        i_appearance_valid = p.av; i_appearance_score = p.as;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        score_q.insert(score_q.size(), s);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand_box();
        int m;
        m = $urandom_range(0, 9);
        if (m == 0) return {$urandom, $urandom};
        return mkbox($urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100,
                     $urandom_range(0, 80) - (m == 1 ? 40 : 0),
                     $urandom_range(0, 80) - (m == 2 ? 40 : 0));
    endfunction

    function automatic t_pair rand_pair();
        t_pair p;
        real a;
        p.det = rand_box();
        if ($urandom_range(0, 3) != 0)
            p.trk = p.det + mkbox($urandom_range(0, 20) - 10, $urandom_range(0, 20) - 10,
                                  $urandom_range(0, 10) - 5, $urandom_range(0, 10) - 5);
        else
            p.trk = rand_box();
        p.obs = $urandom_range(0, 9) == 0 ? p.det : rand_box();
        if ($urandom_range(0, 4) == 0) begin
            p.dx = 16'($urandom);
            p.dy = 16'($urandom);
        end else begin
            a = $urandom_range(0, 6283) / 1000.0;
            p.dx = 16'($rtoi(16384.0 * $cos(a)));
            p.dy = 16'($rtoi(16384.0 * $sin(a)));
        end
        p.av = $urandom_range(0, 1);
        p.as = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, Q15_ONE));
        p.has_exp = 1'b0;
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_score e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (score_q.size() == 0) begin
                $display("%0t unexpected result cost=%0d", $time, o_match_cost);
                errors++;
            end else begin
                e = score_q.pop_front();
                n_checked++;
                if (o_match_cost !== e.cost) begin
                    $display("%0t match_cost exp %0d got %0d", $time, e.cost, o_match_cost);
                    errors++;
                end
                if (o_overlap_ratio !== e.iou) begin
                    $display("%0t overlap_ratio exp %0d got %0d", $time, e.iou,
                             o_overlap_ratio);
                    errors++;
                end
                if (o_motion_blend !== e.motion) begin
                    $display("%0t motion_blend exp %0d got %0d", $time, e.motion,
                             o_motion_blend);
                    errors++;
                end
            end
        end
    end

    initial begin
        int k;
        forever begin
            @(negedge i_clk);
            if (!sink_idle_en || quiet) begin
                i_stall = 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                i_stall = 1'b1;
                k = $urandom_range(1, 12);
                repeat (k - 1) @(negedge i_clk);
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    t_pair dir_rows[$];
    logic [15:0] vw_set[5] = '{16'd0, 16'd32768, 16'd6554, 16'd65535, 16'd20000};
    logic [15:0] aw_set[5] = '{16'd32768, 16'd0, 16'd16384, 16'd65535, 16'd3000};

    task automatic add_row(logic [63:0] d, logic [63:0] t, logic [63:0] o, int dx, int dy,
                           bit av, int as, bit he, int ec, int ei, int em);
        t_pair p;
        p.det = d; p.trk = t; p.obs = o; p.dx = 16'(dx); p.dy = 16'(dy);
        p.av = av; p.as = 16'(as); p.has_exp = he;
        p.e_cost = 16'(ec); p.e_iou = 16'(ei); p.e_motion = 16'(em);
        dir_rows.insert(dir_rows.size(), p);
    endtask

    initial begin
        errors = 0; n_checked = 0; cycles = 0; quiet = 0; sink_idle_en = 0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0;
        i_det_box = '0; i_track_box = '0; i_last_obs_box = '0;
        i_track_dir_x = '0; i_track_dir_y = '0;
        i_appearance_valid = 1'b0; i_appearance_score = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        vel_w = 16'(VEL_WEIGHT_RST); app_w = 16'(APP_WEIGHT_RST);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset weights: vw=6554, center coincident -> direction term 16384
        add_row(mkbox(0, 0, 10, 10), mkbox(0, 0, 10, 10), mkbox(0, 0, 10, 10),
                16384, 0, 0, 0, 1, 29491, 32768, 29491);
        add_row(mkbox(0, 0, 0, 0), mkbox(0, 0, 0, 0), mkbox(0, 0, 0, 0),
                0, 0, 0, 0, 1, 3277, 0, 3277);
        add_row(mkbox(0, 0, 10, 10), mkbox(0, 0, 10, 10), mkbox(0, 0, 10, 10),
                0, 0, 1, 0, 1, 29491, 32768, 29491);
        add_row(mkbox(-32768, -32768, 32767, 32767), mkbox(32767, 32767, -32768, -32768),
                mkbox(32767, -32768, 32767, -32768), 16384, -16384, 1, 32768, 0, 0, 0, 0);
        add_row(mkbox(100, 0, 10, 10), mkbox(0, 0, 10, 10), mkbox(0, 0, 10, 10),
                16384, 0, 0, 0, 0, 0, 0, 0);
        add_row(mkbox(-100, 0, 10, 10), mkbox(0, 0, 10, 10), mkbox(0, 0, 10, 10),
                16384, 0, 1, 65535, 0, 0, 0, 0);
        add_row(mkbox(0, 50, 10, 10), mkbox(0, 45, 10, 10), mkbox(0, 0, 10, 10),
                -32768, 32767, 1, 12345, 0, 0, 0, 0);
        add_row(mkbox(0, 0, -10, 10), mkbox(0, 0, 10, -10), mkbox(3, 3, 4, 4),
                -16384, -16384, 0, 0, 0, 0, 0, 0);
        add_row(mkbox(5, 5, 20, 20), mkbox(0, 0, 20, 20), mkbox(-7, 9, 2, 2),
                11585, 11585, 1, 20000, 0, 0, 0, 0);
        add_row({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, {64{1'b1}}, 64'h0,
                16'h7FFF, 16'h8000, 1, 16'hFFFF, 0, 0, 0, 0);
        foreach (dir_rows[i]) send_pair(dir_rows[i]);
        i_valid = 1'b0;
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            reg_write(ADDR_VELOCITY, {16'hA5A5, vw_set[ph]});
            reg_write(ADDR_APPEARANCE, {16'h5A5A, aw_set[ph]});
            sink_idle_en = 1;
            for (int j = 0; j < 6; j++) send_pair(dir_rows[4 + j]);
            for (int j = 0; j < N_RAND / 5; j++) begin
                if (ph == 4 && j > N_RAND / 10) quiet = 1;
                if (ph == 1 && j == 50) begin
                    i_valid = 1'b0;
                    while (score_q.size() != 0) @(posedge i_clk);
                    @(negedge i_clk);
                end
                send_pair(rand_pair());
            end
            i_valid = 1'b0;
            drain();
        end

        $display("tb: %0d results checked over 5 weight settings incl. 0, 1.0 and 0xFFFF",
                 n_checked);
        $display("tb: directed zero-union, coincident-center and appearance rows included");
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
